/* hw/rtl/lpf_pkg.sv */
// ----------------------------------------------------------------------------
// lpf_pkg
// Shared types and constants of the length-prefixed packet FIFO: request and
// result payloads, opcodes, status codes, and controller/datapath handshake.
// ----------------------------------------------------------------------------
package lpf_pkg;

  localparam int unsigned DEPTH_DEF    = 4096;
  localparam int unsigned BUF_SIZE_RST = 4096;
  localparam int unsigned MIN_RING     = 4;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned STS_W        = 2;
  localparam int unsigned CFG_W        = 13;
  localparam int unsigned FILL_W       = 13;
  localparam int unsigned APB_DW       = 32;
  localparam int unsigned APB_AW       = 3;

  // Opcodes
  localparam logic [OP_W-1:0] OP_WR_HDR  = 3'd0;
  localparam logic [OP_W-1:0] OP_WR_DATA = 3'd1;
  localparam logic [OP_W-1:0] OP_READ    = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK    = 3'd3;
  localparam logic [OP_W-1:0] OP_FLUSH   = 3'd4;

  // Result status codes
  localparam logic [STS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STS_W-1:0] ST_SEQ      = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [LEN_W-1:0]  packet_length;
    logic [BYTE_W-1:0] data_in;
  } lpf_in_t;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic [LEN_W-1:0]  length_out;
    logic [BYTE_W-1:0] data_out;
    logic              byte_valid;
    logic              last_byte;
    logic [FILL_W-1:0] fill_level;
  } lpf_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load_item;   // latch the accepted request
    logic             wr_hdr_hi;   // store length high byte
    logic             wr_hdr_lo;   // store length low byte, open or commit
    logic             wr_data;     // store one payload byte
    logic             fetch;       // read memory at cursor, advance cursor
    logic             hdr_hi_cap;  // capture fetched length high byte
    logic             hdr_lo_cap;  // capture fetched length low byte, open read
    logic             pay_step;    // count one payload byte read
    logic             byte_cap;    // capture fetched payload byte as result
    logic             show_len;    // put front packet length on the result
    logic             finish_rd;   // close the read packet (free or rewind)
    logic             clear;       // flush all pointers and counters
    logic             set_status;
    logic [STS_W-1:0] status;
    logic             set_last;
    logic             out_load;    // move result into output register
  } lpf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            wr_open;
    logic            rd_open;
    logic            fill_zero;
    logic            space_ok;
    logic            len_zero;
    logic            wr_last;
    logic            rd_left_zero;
  } lpf_sts_t;

endpackage

/* hw/rtl/length_prefixed_packet_fifo.sv */
// ----------------------------------------------------------------------------
// length_prefixed_packet_fifo
// Byte ring buffer holding packets stored as a two-byte big-endian length
// followed by the payload; one request in, one result out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request (write header, write data byte, read
//   byte, peek byte, flush); out_valid/out_ready carry its single result.
//   Requests are worked one at a time through a single-port ring memory.
//   A write header makes two memory writes; the first read or peek of a
//   packet makes two extra memory reads to fetch the length.
//   The output register holds a result while the receiver stalls; the next
//   request is still accepted and waits at its last step for the register.
//   Reset empties the buffer and sets the ring size to 4096 (at most DEPTH);
//   memory contents are not cleared. The size register is written at APB
//   addresses 0-3, read at any address; writing it also flushes the buffer.
// ----------------------------------------------------------------------------
module length_prefixed_packet_fifo
  import lpf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpf_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpf_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  lpf_cmd_t cmd;
  lpf_sts_t sts;

  assign pready = 1'b1;

  lpf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpf_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

endmodule

/* hw/rtl/lpf_datapath.sv */
// ----------------------------------------------------------------------------
// lpf_datapath
// Ring memory, write/read pointers, packet counters, size register and the
// result/output registers of the packet FIFO. Driven by lpf_ctrl commands.
// ----------------------------------------------------------------------------
module lpf_datapath
  import lpf_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lpf_cmd_t          cmd,
  output lpf_sts_t          sts,
  input  lpf_in_t           in_data,
  output lpf_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata
);

  localparam int unsigned PW  = $clog2(DEPTH);
  localparam int unsigned RW  = $clog2(DEPTH + 1);
  localparam int unsigned TW  = LEN_W + 1;
  localparam int unsigned CW  = ((RW > TW) ? RW : TW) + 1;
  localparam int unsigned CLW = (RW > CFG_W) ? RW : CFG_W;
  localparam logic [RW-1:0] RS_RST =
    RW'((BUF_SIZE_RST > DEPTH) ? DEPTH : BUF_SIZE_RST);

  // Advance a ring index, wrapping at the ring size
  function automatic logic [PW-1:0] nxt_pos(input logic [PW-1:0] p,
                                            input logic [RW-1:0] rs);
    logic [RW-1:0] q;
    q = RW'(p) + RW'(1);
    return (q >= rs) ? '0 : q[PW-1:0];
  endfunction

  // Clamp a written size into MIN_RING..DEPTH
  function automatic logic [RW-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [CLW-1:0] e;
    e = CLW'(v);
    if (e < CLW'(MIN_RING)) begin
      e = CLW'(MIN_RING);
    end else if (e > CLW'(DEPTH)) begin
      e = CLW'(DEPTH);
    end
    return e[RW-1:0];
  endfunction

  // Control state
  logic [CFG_W-1:0]  bsz_r,       bsz_nxt;
  logic [RW-1:0]     rs_r,        rs_nxt;
  logic [PW-1:0]     wr_ptr_r,    wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r,    rd_ptr_nxt;
  logic [PW-1:0]     cursor_r,    cursor_nxt;
  logic [RW-1:0]     committed_r, committed_nxt;
  logic [LEN_W-1:0]  rd_left_r,   rd_left_nxt;
  logic              rd_open_r,   rd_open_nxt;
  logic [LEN_W-1:0]  wr_left_r,   wr_left_nxt;
  logic [TW-1:0]     wr_total_r,  wr_total_nxt;
  logic              wr_open_r,   wr_open_nxt;

  // Payload registers
  lpf_in_t           item_r;
  logic [BYTE_W-1:0] mem_q [0:DEPTH-1];
  logic [BYTE_W-1:0] mem_rdata_r;
  logic [BYTE_W-1:0] len_hi_r;
  logic [LEN_W-1:0]  rd_len_r;
  logic [STS_W-1:0]  res_status_r;
  logic [LEN_W-1:0]  res_len_r;
  logic [BYTE_W-1:0] res_byte_r;
  logic              res_valid_r;
  logic              res_last_r;
  lpf_out_t          out_r;

  logic              cfg_wr;
  logic              mem_we;
  logic [BYTE_W-1:0] mem_wdata;
  logic [CW-1:0]     rd_total;
  logic [RW-1:0]     freed_cnt;

  assign cfg_wr = psel & penable & pwrite & ~paddr[APB_AW-1];
  assign prdata = APB_DW'(bsz_r);

  // Status toward the controller
  assign sts.op           = item_r.opcode;
  assign sts.wr_open      = wr_open_r;
  assign sts.rd_open      = rd_open_r;
  assign sts.fill_zero    = (committed_r == '0);
  assign sts.space_ok     = ((CW'(rs_r) - CW'(committed_r)) >=
                             (CW'(item_r.packet_length) + CW'(2)));
  assign sts.len_zero     = (item_r.packet_length == '0);
  assign sts.wr_last      = (wr_left_r == LEN_W'(1));
  assign sts.rd_left_zero = (rd_left_r == '0);

  // Bytes left after freeing the front packet
  assign rd_total  = CW'(rd_len_r) + CW'(2);
  assign freed_cnt = (rd_total > CW'(committed_r)) ? '0 :
                     RW'(CW'(committed_r) - rd_total);

  // Next state of pointers and counters
  always_comb begin
    bsz_nxt       = bsz_r;
    rs_nxt        = rs_r;
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    cursor_nxt    = cursor_r;
    committed_nxt = committed_r;
    rd_left_nxt   = rd_left_r;
    rd_open_nxt   = rd_open_r;
    wr_left_nxt   = wr_left_r;
    wr_total_nxt  = wr_total_r;
    wr_open_nxt   = wr_open_r;
    if (cfg_wr || cmd.clear) begin
      if (cfg_wr) begin
        bsz_nxt = pwdata[CFG_W-1:0];
        rs_nxt  = clamp_size(pwdata[CFG_W-1:0]);
      end
      wr_ptr_nxt    = '0;
      rd_ptr_nxt    = '0;
      cursor_nxt    = '0;
      committed_nxt = '0;
      rd_left_nxt   = '0;
      rd_open_nxt   = 1'b0;
      wr_left_nxt   = '0;
      wr_total_nxt  = '0;
      wr_open_nxt   = 1'b0;
    end else begin
      // write side
      if (cmd.wr_hdr_hi || cmd.wr_hdr_lo || cmd.wr_data) begin
        wr_ptr_nxt = nxt_pos(wr_ptr_r, rs_r);
      end
      if (cmd.wr_hdr_lo) begin
        if (item_r.packet_length == '0) begin
          committed_nxt = committed_r + RW'(2);
        end else begin
          wr_open_nxt  = 1'b1;
          wr_left_nxt  = item_r.packet_length;
          wr_total_nxt = TW'(item_r.packet_length) + TW'(2);
        end
      end
      if (cmd.wr_data) begin
        wr_left_nxt = wr_left_r - LEN_W'(1);
        if (wr_left_r == LEN_W'(1)) begin
          committed_nxt = RW'(CW'(committed_r) + CW'(wr_total_r));
          wr_total_nxt  = '0;
          wr_open_nxt   = 1'b0;
        end
      end
      // read side
      if (cmd.fetch) begin
        cursor_nxt = nxt_pos(cursor_r, rs_r);
      end
      if (cmd.hdr_lo_cap) begin
        rd_open_nxt = 1'b1;
        rd_left_nxt = {len_hi_r, mem_rdata_r};
      end
      if (cmd.pay_step) begin
        rd_left_nxt = rd_left_r - LEN_W'(1);
      end
      if (cmd.finish_rd) begin
        rd_open_nxt = 1'b0;
        rd_left_nxt = '0;
        if (item_r.opcode == OP_READ) begin
          rd_ptr_nxt    = cursor_r;
          committed_nxt = freed_cnt;
        end else begin
          cursor_nxt = rd_ptr_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bsz_r       <= CFG_W'(BUF_SIZE_RST);
      rs_r        <= RS_RST;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      cursor_r    <= '0;
      committed_r <= '0;
      rd_left_r   <= '0;
      rd_open_r   <= 1'b0;
      wr_left_r   <= '0;
      wr_total_r  <= '0;
      wr_open_r   <= 1'b0;
    end else begin
      bsz_r       <= bsz_nxt;
      rs_r        <= rs_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cursor_r    <= cursor_nxt;
      committed_r <= committed_nxt;
      rd_left_r   <= rd_left_nxt;
      rd_open_r   <= rd_open_nxt;
      wr_left_r   <= wr_left_nxt;
      wr_total_r  <= wr_total_nxt;
      wr_open_r   <= wr_open_nxt;
    end
  end

  // Ring memory: one access per cycle, registered read
  assign mem_we = cmd.wr_hdr_hi | cmd.wr_hdr_lo | cmd.wr_data;

  always_comb begin
    if (cmd.wr_hdr_hi) begin
      mem_wdata = item_r.packet_length[LEN_W-1:BYTE_W];
    end else if (cmd.wr_hdr_lo) begin
      mem_wdata = item_r.packet_length[BYTE_W-1:0];
    end else begin
      mem_wdata = item_r.data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_q[wr_ptr_r] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      mem_rdata_r <= mem_q[cursor_r];
    end
  end

  // Request latch and front packet length
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.hdr_hi_cap) begin
      len_hi_r <= mem_rdata_r;
    end
    if (cmd.hdr_lo_cap) begin
      rd_len_r <= {len_hi_r, mem_rdata_r};
    end
  end

  // Build the result, then hold it in the output register
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      res_status_r <= ST_OK;
      res_len_r    <= '0;
      res_byte_r   <= '0;
      res_valid_r  <= 1'b0;
      res_last_r   <= 1'b0;
    end else begin
      if (cmd.set_status) begin
        res_status_r <= cmd.status;
      end
      if (cmd.show_len) begin
        res_len_r <= rd_len_r;
      end
      if (cmd.byte_cap) begin
        res_byte_r  <= mem_rdata_r;
        res_valid_r <= 1'b1;
      end
      if (cmd.set_last) begin
        res_last_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_r.status     <= res_status_r;
      out_r.length_out <= res_len_r;
      out_r.data_out   <= res_byte_r;
      out_r.byte_valid <= res_valid_r;
      out_r.last_byte  <= res_last_r;
      out_r.fill_level <= FILL_W'(committed_r);
    end
  end

  assign out_data = out_r;

`ifndef SYNTH
  a_fill_le_ring: assert property (@(posedge clk) disable iff (!rst_n)
    committed_r <= rs_r)
    else $error("fill level exceeds ring size");

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (RW'(wr_ptr_r) < rs_r) && (RW'(rd_ptr_r) < rs_r) && (RW'(cursor_r) < rs_r))
    else $error("ring index beyond ring size");

  a_open_read_has_fill: assert property (@(posedge clk) disable iff (!rst_n)
    rd_open_r |-> (committed_r != '0))
    else $error("open read packet with empty buffer");
`endif

endmodule

/* hw/rtl/lpf_ctrl.sv */
// ----------------------------------------------------------------------------
// lpf_ctrl
// Sequencer of the packet FIFO: accepts a request, steps the datapath through
// its memory accesses, and hands the result to the output register.
// ----------------------------------------------------------------------------
module lpf_ctrl
  import lpf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  lpf_sts_t sts,
  output lpf_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_HDR_LO,
    S_HDR_RD1,
    S_HDR_RD2,
    S_PAY,
    S_PAY_WAIT,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Commands and next state
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_RESP;
        unique case (sts.op) inside
          OP_WR_HDR: begin
            if (sts.wr_open) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_SEQ;
            end else if (!sts.space_ok) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NO_SPACE;
            end else begin
              cmd.wr_hdr_hi = 1'b1;
              state_nxt     = S_HDR_LO;
            end
          end
          OP_WR_DATA: begin
            if (!sts.wr_open) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_SEQ;
            end else begin
              cmd.wr_data  = 1'b1;
              cmd.set_last = sts.wr_last;
            end
          end
          OP_READ, OP_PEEK: begin
            if (!sts.rd_open && sts.fill_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_EMPTY;
            end else if (!sts.rd_open) begin
              cmd.fetch = 1'b1;
              state_nxt = S_HDR_RD1;
            end else begin
              state_nxt = S_PAY;
            end
          end
          OP_FLUSH: begin
            cmd.clear = 1'b1;
          end
          default: begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_SEQ;
          end
        endcase
      end
      S_HDR_LO: begin
        cmd.wr_hdr_lo = 1'b1;
        cmd.set_last  = sts.len_zero;
        state_nxt     = S_RESP;
      end
      S_HDR_RD1: begin
        cmd.hdr_hi_cap = 1'b1;
        cmd.fetch      = 1'b1;
        state_nxt      = S_HDR_RD2;
      end
      S_HDR_RD2: begin
        cmd.hdr_lo_cap = 1'b1;
        state_nxt      = S_PAY;
      end
      S_PAY: begin
        cmd.show_len = 1'b1;
        if (sts.rd_left_zero) begin
          cmd.set_last  = 1'b1;
          cmd.finish_rd = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.fetch    = 1'b1;
          cmd.pay_step = 1'b1;
          state_nxt    = S_PAY_WAIT;
        end
      end
      S_PAY_WAIT: begin
        cmd.byte_cap = 1'b1;
        if (sts.rd_left_zero) begin
          cmd.set_last  = 1'b1;
          cmd.finish_rd = 1'b1;
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken result");

  a_accept_decodes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_DECODE) && !in_ready)
    else $error("accepted request not decoded");

  a_byte_after_fetch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PAY_WAIT) |-> $past(cmd.fetch && cmd.pay_step))
    else $error("payload capture without a memory fetch");
`endif

endmodule
